@@ src/ssid_pkg.sv @@
// Shared types and codes for the sorted set insert/delete block.
package ssid_pkg;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_DUMP   = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      RSP_INSERTED   = 3'd0,
      RSP_DUPLICATE  = 3'd1,
      RSP_FULL       = 3'd2,
      RSP_DELETED    = 3'd3,
      RSP_NOT_FOUND  = 3'd4,
      RSP_DUMP_ENTRY = 3'd5,
      RSP_DUMP_EMPTY = 3'd6
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_DEL_SHIFT,
      ST_DUMP
   } state_type;

endpackage

@@ src/sorted_set_insert_delete.sv @@
// Sorted set of signed 32-bit values held in ascending order in a memory with one read port
// and one write port.
// A request is taken when start is high and busy is low. The block works on one request at
// a time: for an insert or delete it scans the memory from the bottom, one entry per cycle,
// until it finds the first stored value not below the request value, then, where needed,
// shifts the entries above that point by one place, again one entry per cycle, through the
// memory's single read and single write port. An insert or delete on an empty set, or a dump
// of an empty set, is answered without busy going high. A dump of n values delivers one
// result per cycle, from the bottom entry upward. Every result appears for exactly
// one cycle with rsp_strobe high and cannot be held off; rsp_last marks the final result of
// a request. A request type of 3 is dropped without a result.
module sorted_set_insert_delete
   import ssid_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic               rsp_last
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic signed [31:0] mem [CAPACITY];

   state_type          state_ff, state_in;
   req_code_type       req_type_ff, req_type_in;
   logic signed [31:0] req_value_ff, req_value_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic               rd_more_ff, rd_more_in;
   logic               dv_ff;
   logic [CW-1:0]      dv_idx_ff;
   logic signed [31:0] rd_data_ff;

   logic               rsp_strobe_ff;
   rsp_status_type     rsp_status_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic               rd_en;
   logic               mem_we;
   logic [CW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               emit;
   rsp_status_type     emit_status;
   logic signed [31:0] emit_value;
   logic               emit_last;

   logic               is_insert;
   logic [CW-1:0]      last_idx;
   logic               below;
   logic               scan_hit;
   logic               scan_end;
   logic               scan_stop;
   logic               scan_eq;
   logic [CW-1:0]      scan_pos;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign is_insert = (req_type_ff == REQ_INSERT);
   assign last_idx  = CW'(count_ff - 1'b1);
   assign below     = (rd_data_ff < req_value_ff);
   // The scan stops at the first entry not below the value, or past the top entry.
   assign scan_hit  = dv_ff && !below;
   assign scan_end  = dv_ff && below && (dv_idx_ff == last_idx);
   assign scan_stop = scan_hit || scan_end;
   assign scan_eq   = scan_hit && (rd_data_ff == req_value_ff);
   assign scan_pos  = scan_hit ? dv_idx_ff : count_ff;

   assign req_type_in  = accept ? req_code_type'(req_type) : req_type_ff;
   assign req_value_in = accept ? req_value : req_value_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (count_ff != '0)) begin
               case (req_code_type'(req_type))
                  REQ_INSERT: state_in = ST_SCAN;
                  REQ_DELETE: state_in = ST_SCAN;
                  REQ_DUMP:   state_in = ST_DUMP;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_stop) begin
               if (is_insert) begin
                  if (!scan_eq && (count_ff != CW'(CAPACITY)) && (scan_pos != count_ff)) begin
                     state_in = ST_INS_SHIFT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  if (scan_eq && (scan_pos != last_idx)) begin
                     state_in = ST_DEL_SHIFT;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_INS_SHIFT: begin
            if (dv_ff && (dv_idx_ff == pos_ff)) begin
               state_in = ST_INS_PUT;
            end
         end
         ST_INS_PUT: state_in = ST_IDLE;
         ST_DEL_SHIFT: begin
            if (dv_ff && (dv_idx_ff == last_idx)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (dv_ff && (dv_idx_ff == last_idx)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Memory accesses, counters and results.
   always_comb begin
      rd_en       = 1'b0;
      rd_ptr_in   = rd_ptr_ff;
      rd_more_in  = rd_more_ff;
      mem_we      = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = req_value_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      emit        = 1'b0;
      emit_status = RSP_INSERTED;
      emit_value  = req_value_ff;
      emit_last   = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               emit_value = req_value;
               rd_ptr_in  = '0;
               rd_more_in = 1'b1;
               if (count_ff == '0) begin
                  case (req_code_type'(req_type))
                     REQ_INSERT: begin
                        mem_we      = 1'b1;
                        wr_addr     = '0;
                        wr_data     = req_value;
                        count_in    = CW'(1);
                        emit        = 1'b1;
                        emit_status = RSP_INSERTED;
                     end
                     REQ_DELETE: begin
                        emit        = 1'b1;
                        emit_status = RSP_NOT_FOUND;
                     end
                     REQ_DUMP: begin
                        emit        = 1'b1;
                        emit_status = RSP_DUMP_EMPTY;
                     end
                     default: emit = 1'b0;
                  endcase
               end
            end
         end
         ST_SCAN: begin
            if (scan_stop) begin
               pos_in = scan_pos;
               if (is_insert) begin
                  if (scan_eq) begin
                     emit        = 1'b1;
                     emit_status = RSP_DUPLICATE;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     emit        = 1'b1;
                     emit_status = RSP_FULL;
                  end else if (scan_pos == count_ff) begin
                     mem_we      = 1'b1;
                     wr_addr     = count_ff;
                     count_in    = CW'(count_ff + 1'b1);
                     emit        = 1'b1;
                     emit_status = RSP_INSERTED;
                  end else begin
                     // Shift from the top entry down to the insert position.
                     rd_ptr_in  = last_idx;
                     rd_more_in = 1'b1;
                  end
               end else begin
                  if (!scan_eq) begin
                     emit        = 1'b1;
                     emit_status = RSP_NOT_FOUND;
                  end else if (scan_pos == last_idx) begin
                     count_in    = last_idx;
                     emit        = 1'b1;
                     emit_status = RSP_DELETED;
                  end else begin
                     rd_ptr_in  = CW'(scan_pos + 1'b1);
                     rd_more_in = 1'b1;
                  end
               end
            end else if (rd_more_ff) begin
               rd_en      = 1'b1;
               rd_ptr_in  = CW'(rd_ptr_ff + 1'b1);
               rd_more_in = (rd_ptr_ff != last_idx);
            end
         end
         ST_INS_SHIFT: begin
            // Reads run two entries below the write, so they never meet.
            if (rd_more_ff) begin
               rd_en      = 1'b1;
               rd_ptr_in  = CW'(rd_ptr_ff - 1'b1);
               rd_more_in = (rd_ptr_ff != pos_ff);
            end
            if (dv_ff) begin
               mem_we  = 1'b1;
               wr_addr = CW'(dv_idx_ff + 1'b1);
               wr_data = rd_data_ff;
            end
         end
         ST_INS_PUT: begin
            mem_we      = 1'b1;
            wr_addr     = pos_ff;
            count_in    = CW'(count_ff + 1'b1);
            emit        = 1'b1;
            emit_status = RSP_INSERTED;
         end
         ST_DEL_SHIFT: begin
            if (rd_more_ff) begin
               rd_en      = 1'b1;
               rd_ptr_in  = CW'(rd_ptr_ff + 1'b1);
               rd_more_in = (rd_ptr_ff != last_idx);
            end
            if (dv_ff) begin
               mem_we  = 1'b1;
               wr_addr = CW'(dv_idx_ff - 1'b1);
               wr_data = rd_data_ff;
               if (dv_idx_ff == last_idx) begin
                  count_in    = last_idx;
                  emit        = 1'b1;
                  emit_status = RSP_DELETED;
               end
            end
         end
         ST_DUMP: begin
            if (rd_more_ff) begin
               rd_en      = 1'b1;
               rd_ptr_in  = CW'(rd_ptr_ff + 1'b1);
               rd_more_in = (rd_ptr_ff != last_idx);
            end
            if (dv_ff) begin
               emit        = 1'b1;
               emit_status = RSP_DUMP_ENTRY;
               emit_value  = rd_data_ff;
               emit_last   = (dv_idx_ff == last_idx);
            end
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr[IW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rd_more_ff    <= 1'b0;
         dv_ff         <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rd_more_ff    <= rd_more_in;
         dv_ff         <= rd_en;
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff   <= req_type_in;
      req_value_ff  <= req_value_in;
      pos_ff        <= pos_in;
      rd_ptr_ff     <= rd_ptr_in;
      dv_idx_ff     <= rd_ptr_ff;
      rsp_status_ff <= emit_status;
      rsp_value_ff  <= emit_value;
      rsp_last_ff   <= emit_last;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ((count_ff == CW'($past(count_ff) + 1'b1)) ||
          (count_ff == CW'($past(count_ff) - 1'b1))))
      else $error("entry count moved by more than one");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_en) |-> (wr_addr != rd_ptr_ff))
      else $error("memory read and write hit the same entry");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !$past(reset)) |-> $past((state_ff != ST_IDLE) || accept))
      else $error("result without a request in progress");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sorted set insert/delete block.
module testbench
   import ssid_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAPACITY = 64;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_PRINTED = 30;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      rsp_status_type     status;
      logic signed [31:0] value;
      logic               last;
   } set_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = REQ_INSERT;
   logic signed [31:0] req_value = '0;
   logic               rsp_strobe;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_out_value;
   logic               rsp_last;

   logic signed [31:0] stored_values[$];
   set_result_type     expected_results[$];
   int                 error_count = 0;
   bit                 idle_on = 1'b1;

   sorted_set_insert_delete #(
      .CAPACITY(SET_CAPACITY)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_type     (req_type),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_out_value(rsp_out_value),
      .rsp_last     (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTED) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic void queue_result(rsp_status_type status, logic signed [31:0] value,
                                        logic last);
      set_result_type item;
      item.status = status;
      item.value = value;
      item.last = last;
      expected_results.push_back(item);
   endfunction

   // Index of the first stored value that is not below v.
   function automatic int lower_index(logic signed [31:0] v);
      int i;
      i = 0;
      while (i < stored_values.size() && stored_values[i] < v) i++;
      return i;
   endfunction

   // Applies one accepted request to the set copy and queues the results it causes.
   function automatic void predict_request(logic [1:0] code, logic signed [31:0] v);
      int  pos;
      bit  hit;
      pos = lower_index(v);
      hit = (pos < stored_values.size()) && (stored_values[pos] == v);
      case (code)
         REQ_INSERT: begin
            if (hit) begin
               queue_result(RSP_DUPLICATE, v, 1'b1);
            end else if (stored_values.size() >= SET_CAPACITY) begin
               queue_result(RSP_FULL, v, 1'b1);
            end else begin
               stored_values.insert(pos, v);
               queue_result(RSP_INSERTED, v, 1'b1);
            end
         end
         REQ_DELETE: begin
            if (hit) begin
               stored_values.delete(pos);
               queue_result(RSP_DELETED, v, 1'b1);
            end else begin
               queue_result(RSP_NOT_FOUND, v, 1'b1);
            end
         end
         REQ_DUMP: begin
            if (stored_values.size() == 0) begin
               queue_result(RSP_DUMP_EMPTY, v, 1'b1);
            end else begin
               foreach (stored_values[i]) begin
                  queue_result(RSP_DUMP_ENTRY, stored_values[i],
                               i == stored_values.size() - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         case ($urandom_range(0, 4))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      // A narrow band of small values makes duplicates and delete hits common.
      if (r < 40) return int'($urandom_range(0, 40)) - 20;
      if (r < 70 && stored_values.size() > 0) begin
         return stored_values[$urandom_range(0, stored_values.size() - 1)];
      end
      return $urandom();
   endfunction

   // Holds start high until the request is taken, then predicts its results.
   task automatic send_request(logic [1:0] code, logic signed [31:0] v);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_type <= code;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_request(code, v);
   endtask

   task automatic test_directed();
      idle_on = 1'b0;
      send_request(REQ_DUMP, 32'sh5A5A_A5A5);
      send_request(REQ_DELETE, 32'sd7);
      send_request(REQ_INSERT, 32'sd0);
      send_request(REQ_INSERT, VALUE_MIN);
      send_request(REQ_INSERT, VALUE_MAX);
      send_request(REQ_INSERT, -32'sd1);
      send_request(REQ_INSERT, 32'sd1);
      send_request(REQ_INSERT, 32'sd0);
      send_request(REQ_INSERT, VALUE_MIN);
      send_request(REQ_DUMP, 32'sd0);
      send_request(REQ_UNUSED, 32'sd1);
      send_request(REQ_DELETE, VALUE_MAX);
      send_request(REQ_DELETE, 32'sd7);
      send_request(REQ_DELETE, VALUE_MIN);
      idle_on = 1'b1;
      send_request(REQ_DUMP, VALUE_MAX);
      send_request(REQ_DELETE, 32'sd0);
      send_request(REQ_DELETE, -32'sd1);
      send_request(REQ_DELETE, 32'sd1);
      send_request(REQ_DELETE, 32'sd1);
      send_request(REQ_DUMP, -32'sd1);
      send_request(REQ_INSERT, VALUE_MAX);
      send_request(REQ_UNUSED, VALUE_MIN);
      send_request(REQ_DELETE, VALUE_MAX);
   endtask

   task automatic test_fill_to_capacity();
      int guard;
      guard = 0;
      idle_on = 1'b1;
      while (stored_values.size() < SET_CAPACITY && guard < 200) begin
         guard++;
         if (guard % 25 == 0) idle_on = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 9))
            0: send_request(REQ_DUMP, $urandom());
            1, 2: send_request(REQ_INSERT, pick_value());
            default: send_request(REQ_INSERT, $urandom());
         endcase
      end
      idle_on = 1'b1;
      // With the set full, new values are refused but duplicates still report as such.
      send_request(REQ_INSERT, $urandom());
      send_request(REQ_INSERT, pick_value());
      send_request(REQ_INSERT, stored_values[0]);
      send_request(REQ_INSERT, stored_values[stored_values.size() - 1]);
      send_request(REQ_DUMP, $urandom());
      send_request(REQ_DELETE, stored_values[$urandom_range(0, stored_values.size() - 1)]);
      send_request(REQ_INSERT, $urandom());
      send_request(REQ_INSERT, $urandom());
      send_request(REQ_DUMP, $urandom());
   endtask

   task automatic test_drain();
      int guard;
      guard = 0;
      while (stored_values.size() > 0 && guard < 150) begin
         guard++;
         if (guard % 20 == 0) idle_on = ($urandom_range(0, 2) != 0);
         case ($urandom_range(0, 9))
            0: send_request(REQ_DUMP, $urandom());
            1, 2: send_request(REQ_DELETE, pick_value());
            default: begin
               send_request(REQ_DELETE,
                            stored_values[$urandom_range(0, stored_values.size() - 1)]);
            end
         endcase
      end
      idle_on = 1'b1;
      send_request(REQ_DUMP, $urandom());
   endtask

   task automatic test_random_mix();
      int n;
      int r;
      n = 0;
      while (n < 70) begin
         if (n % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
         r = $urandom_range(0, 99);
         if (r < 5) begin
            send_request(REQ_UNUSED, $urandom());
         end else begin
            n++;
            if (r < 55) send_request(REQ_INSERT, pick_value());
            else if (r < 88) send_request(REQ_DELETE, pick_value());
            else send_request(REQ_DUMP, $urandom());
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      set_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result status %0d value %0d last %0b",
                                      rsp_status, rsp_out_value, rsp_last));
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status,
                                         want.status));
            end
            if (rsp_out_value !== want.value) begin
               report_mismatch($sformatf("out_value %0d, expected %0d", rsp_out_value,
                                         want.value));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_to_capacity();
      test_drain();
      test_random_mix();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      // Extra cycles catch any result the block sends beyond what was predicted.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/ssid_pkg.sv
src/sorted_set_insert_delete.sv
tb/testbench.sv
